@@ src/echo_ranging_and_wheel_odometry_core_defines.svh @@
// ---------------------------------------------------------------------------
// Echo ranging and wheel odometry: assertion macros
// Shared macros for the concurrent checks of the core.
// ---------------------------------------------------------------------------
`ifndef ECHO_RANGING_AND_WHEEL_ODOMETRY_CORE_DEFINES_SVH
`define ECHO_RANGING_AND_WHEEL_ODOMETRY_CORE_DEFINES_SVH

// Property checked at every rising clock edge while reset is released.
`define ERWO_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define ERWO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/erwo_pkg.sv @@
// ---------------------------------------------------------------------------
// Echo ranging and wheel odometry package
// Constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package erwo_pkg;

  // Event kinds carried by func.
  localparam logic [1:0] FUNC_LEFT  = 2'd0;
  localparam logic [1:0] FUNC_RIGHT = 2'd1;
  localparam logic [1:0] FUNC_RISE  = 2'd2;
  localparam logic [1:0] FUNC_FALL  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ECHO_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_ENC_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_SAFETY_THR   = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [19:0] ECHO_TIMEOUT_RST = 20'd26100;
  localparam logic [31:0] ENC_TIMEOUT_RST  = 32'd1000000;
  localparam logic [27:0] SAFETY_THR_RST   = 28'd180000;

  // Wheel speed numerator in um/s times us, distance per notch, sound speed.
  localparam logic [33:0] SPEED_NUM = 34'd10250000000;
  localparam logic [12:0] NOTCH_UM  = 13'd5125;
  localparam logic [8:0]  SOUND_UM  = 9'd343;

  localparam int unsigned DivSteps = 34;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_DONE = 6'b100000
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic sum;
    logic mul;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_req;
    logic div_last;
    logic slot_free;
  } dpath_sts_t;

endpackage

@@ src/echo_ranging_and_wheel_odometry_core.sv @@
// ---------------------------------------------------------------------------
// Echo ranging and wheel odometry core
// Turns timestamped encoder and echo pin events into odometry and range data.
// ---------------------------------------------------------------------------
// Usage. Each input item is one pin event (func, timestamp_us) offered on a
// valid/ready channel. Every accepted item yields exactly one result item on
// the output valid/ready channel carrying pulse counts, travelled distance,
// wheel speeds, their mean, the last obstacle distance and the blocked and
// stop flags as they stand after that event.
// Flow. An item passes evaluate, then the speed division when an encoder
// edge needs one, then sum and multiply, and is then emitted into the output
// register. The division is done by the radix-2 divider that forms
// 10250000000 / interval one quotient bit per cycle. One item is in flight at
// a time; the next item is taken once the previous result sits in the output
// register, even while the receiver has not yet taken it.
// Stalls. If the receiver holds ready low, the finished result waits in the
// output register and the following item waits in its last stage until the
// register frees up; nothing is dropped or repeated.
// Reset. rst_ni zeroes all counters, speeds, the echo state and the flags,
// and loads the configuration registers with their defaults. The user must
// write the configuration port only while no item is in flight; unchecked.
// ---------------------------------------------------------------------------
module echo_ranging_and_wheel_odometry_core import erwo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [31:0]         timestamp_us_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         left_count_o,
  output logic [31:0]         right_count_o,
  output logic [45:0]         travelled_um_o,
  output logic [33:0]         left_speed_ums_o,
  output logic [33:0]         right_speed_ums_o,
  output logic [33:0]         mean_speed_ums_o,
  output logic [27:0]         obstacle_um_o,
  output logic                path_blocked_o,
  output logic                stop_request_o
);

  // The controller sees only the handshake and the datapath status; all
  // arithmetic and the odometry and echo state live in the datapath.
  ctrl_cmd_t  cmd;
  dpath_sts_t sts;

  erwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  erwo_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .func_i            (func_i),
    .timestamp_us_i    (timestamp_us_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .left_count_o      (left_count_o),
    .right_count_o     (right_count_o),
    .travelled_um_o    (travelled_um_o),
    .left_speed_ums_o  (left_speed_ums_o),
    .right_speed_ums_o (right_speed_ums_o),
    .mean_speed_ums_o  (mean_speed_ums_o),
    .obstacle_um_o     (obstacle_um_o),
    .path_blocked_o    (path_blocked_o),
    .stop_request_o    (stop_request_o)
  );

endmodule

@@ src/erwo_ctrl.sv @@
// ---------------------------------------------------------------------------
// Echo ranging and wheel odometry controller
// Sequences one event through evaluate, an optional divide, sum, multiply and emit.
// ---------------------------------------------------------------------------
module erwo_ctrl import erwo_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dpath_sts_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.div_req ? ST_DIV : ST_SUM;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // The result register must be empty or draining this cycle.
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/erwo_dpath.sv @@
// ---------------------------------------------------------------------------
// Echo ranging and wheel odometry datapath
// Odometry and echo state, radix-2 speed divider and the result register.
// ---------------------------------------------------------------------------
module erwo_dpath import erwo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dpath_sts_t          sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [1:0]          func_i,
  input  logic [31:0]         timestamp_us_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         left_count_o,
  output logic [31:0]         right_count_o,
  output logic [45:0]         travelled_um_o,
  output logic [33:0]         left_speed_ums_o,
  output logic [33:0]         right_speed_ums_o,
  output logic [33:0]         mean_speed_ums_o,
  output logic [27:0]         obstacle_um_o,
  output logic                path_blocked_o,
  output logic                stop_request_o
);

  // Configuration.
  logic [19:0] echo_to_q;
  logic [31:0] enc_to_q;
  logic [27:0] thr_q;

  // Architectural state.
  logic [31:0] left_last_q, right_last_q, left_pulses_q, right_pulses_q;
  logic [33:0] left_speed_q, right_speed_q;
  logic [31:0] echo_start_q;
  logic [27:0] obstacle_q;
  logic        blocked_q, stop_q, echo_upd_q;
  logic        out_valid_q;

  // Working registers.
  logic [1:0]         func_q;
  logic [31:0]        ts_q;
  logic [31:0]        div_q, rem_q;
  logic [33:0]        quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic [32:0]        pulse_sum_q;
  logic [34:0]        speed_sum_q;
  logic [45:0]        trav_q;

  logic [31:0] interval, pulse;
  logic        is_enc, div_req, echo_ok;
  logic [28:0] dist_prod;
  logic [32:0] rem_sh, rem_sub;
  logic        rem_ge;
  logic [33:0] quo_nx;

  always_comb begin
    is_enc    = (func_q == FUNC_LEFT) || (func_q == FUNC_RIGHT);
    interval  = ts_q - ((func_q == FUNC_RIGHT) ? right_last_q : left_last_q);
    div_req   = is_enc && (interval != 32'd0) && (interval <= enc_to_q);
    pulse     = ts_q - echo_start_q;
    echo_ok   = pulse <= {12'd0, echo_to_q};
    dist_prod = {9'd0, pulse[19:0]} * {20'd0, SOUND_UM};
    rem_sh    = {rem_q, quo_q[33]};
    rem_ge    = rem_sh >= {1'b0, div_q};
    rem_sub   = rem_sh - {1'b0, div_q};
    quo_nx    = {quo_q[32:0], rem_ge};
  end

  assign sts_o.div_req   = div_req;
  assign sts_o.div_last  = (cnt_q == DivCntW'(1));
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_to_q <= ECHO_TIMEOUT_RST;
      enc_to_q  <= ENC_TIMEOUT_RST;
      thr_q     <= SAFETY_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ECHO_TIMEOUT: echo_to_q <= cfg_wdata_i[19:0];
        CFG_ENC_TIMEOUT:  enc_to_q  <= cfg_wdata_i[31:0];
        CFG_SAFETY_THR:   thr_q     <= cfg_wdata_i[27:0];
        default: begin
        end
      endcase
    end
  end

  // Odometry and echo state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_last_q    <= '0;
      right_last_q   <= '0;
      left_pulses_q  <= '0;
      right_pulses_q <= '0;
      left_speed_q   <= '0;
      right_speed_q  <= '0;
      echo_start_q   <= '0;
      obstacle_q     <= '0;
      blocked_q      <= 1'b0;
      stop_q         <= 1'b0;
      echo_upd_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        echo_upd_q <= 1'b0;
        case (func_q)
          FUNC_LEFT: begin
            left_pulses_q <= left_pulses_q + 32'd1;
            left_last_q   <= ts_q;
            if (!div_req) begin
              left_speed_q <= '0;
            end
          end
          FUNC_RIGHT: begin
            right_pulses_q <= right_pulses_q + 32'd1;
            right_last_q   <= ts_q;
            if (!div_req) begin
              right_speed_q <= '0;
            end
          end
          FUNC_RISE: begin
            echo_start_q <= ts_q;
          end
          default: begin
            // Echo fall: an overlong pulse only restarts the echo timer.
            if (echo_ok) begin
              obstacle_q <= dist_prod[28:1];
              echo_upd_q <= 1'b1;
            end else begin
              echo_start_q <= ts_q;
            end
          end
        endcase
      end
      if (cmd_i.div_step && sts_o.div_last) begin
        if (func_q == FUNC_RIGHT) begin
          right_speed_q <= quo_nx;
        end else begin
          left_speed_q <= quo_nx;
        end
      end
      if (cmd_i.sum) begin
        stop_q <= 1'b0;
        if (echo_upd_q) begin
          if (obstacle_q <= thr_q) begin
            if (!blocked_q) begin
              blocked_q <= 1'b1;
              stop_q    <= 1'b1;
            end
          end else begin
            blocked_q <= 1'b0;
          end
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event capture, divider iterations, sums and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      ts_q   <= timestamp_us_i;
    end
    if (cmd_i.eval) begin
      div_q <= interval;
      rem_q <= '0;
      quo_q <= SPEED_NUM;
      cnt_q <= DivCntW'(DivSteps);
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_q <= quo_nx;
      cnt_q <= cnt_q - DivCntW'(1);
    end
    if (cmd_i.sum) begin
      pulse_sum_q <= {1'b0, left_pulses_q} + {1'b0, right_pulses_q};
      speed_sum_q <= {1'b0, left_speed_q} + {1'b0, right_speed_q};
    end
    if (cmd_i.mul) begin
      trav_q <= {13'd0, pulse_sum_q} * {33'd0, NOTCH_UM};
    end
    if (cmd_i.emit) begin
      left_count_o      <= left_pulses_q;
      right_count_o     <= right_pulses_q;
      travelled_um_o    <= trav_q;
      left_speed_ums_o  <= left_speed_q;
      right_speed_ums_o <= right_speed_q;
      mean_speed_ums_o  <= speed_sum_q[34:1];
      obstacle_um_o     <= obstacle_q;
      path_blocked_o    <= blocked_q;
      stop_request_o    <= stop_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/erwo_checker.sv @@
// ---------------------------------------------------------------------------
// Echo ranging and wheel odometry checker
// Port-level consistency checks, bound to the core.
// ---------------------------------------------------------------------------
`include "echo_ranging_and_wheel_odometry_core_defines.svh"

module erwo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic [31:0] left_count_o,
  input logic [31:0] right_count_o,
  input logic [45:0] travelled_um_o,
  input logic [33:0] left_speed_ums_o,
  input logic [33:0] right_speed_ums_o,
  input logic [33:0] mean_speed_ums_o,
  input logic        path_blocked_o,
  input logic        stop_request_o
);

  logic [32:0] count_sum;
  logic [45:0] trav_expect;
  logic [34:0] speed_sum;

  assign count_sum   = {1'b0, left_count_o} + {1'b0, right_count_o};
  assign trav_expect = {13'd0, count_sum} * 46'd5125;
  assign speed_sum   = {1'b0, left_speed_ums_o} + {1'b0, right_speed_ums_o};

  // A stop request only accompanies a result that reports the path blocked.
  `ERWO_ASSERT_RST(a_stop_implies_blocked, clk_i, rst_ni,
    out_valid_o && stop_request_o |-> path_blocked_o, "stop without blocked")

  // Travelled distance follows the reported pulse counts.
  `ERWO_ASSERT_RST(a_travelled, clk_i, rst_ni,
    out_valid_o |-> travelled_um_o == trav_expect, "travelled distance mismatch")

  // Mean speed is the truncated average of the two reported speeds.
  `ERWO_ASSERT_RST(a_mean_speed, clk_i, rst_ni,
    out_valid_o |-> mean_speed_ums_o == speed_sum[34:1], "mean speed mismatch")

  // No wheel speed can exceed the one-microsecond interval value.
  `ERWO_ASSERT_RST(a_speed_bound, clk_i, rst_ni,
    out_valid_o |-> (left_speed_ums_o <= 34'd10250000000) &&
                    (right_speed_ums_o <= 34'd10250000000), "speed out of range")

  // Right after reset no result can be pending.
  `ERWO_ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind echo_ranging_and_wheel_odometry_core erwo_checker u_erwo_checker (.*);
